>>> sv/hbk_pkg.sv
// Shared types, constants and key map for the HID boot keyboard decoder.
// No dependencies; every other file refers to this package by scoped names.
package hbk_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int SLOT_W    = $clog2(KEY_SLOTS);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CAPS_CODE       = 8'h39;
    localparam logic [7:0] KEY_C_CODE      = 8'h06;
    localparam logic [7:0] KEY_BSLASH_CODE = 8'h31;
    localparam logic [7:0] LETTER_FIRST    = 8'h04;
    localparam logic [7:0] LETTER_LAST     = 8'h1D;
    localparam logic [7:0] SYM_FIRST       = 8'h1E;
    localparam logic [7:0] SYM_LAST        = 8'h38;
    localparam logic [7:0] MOD_CTRL        = 8'h11;
    localparam logic [7:0] MOD_SHIFT       = 8'h22;

    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_INTR = 2'd1;
    localparam logic [1:0] EV_QUIT = 2'd2;

    typedef logic [KEY_SLOTS-1:0][7:0] keys_t;

    // one classified report: which slots give an event, and what each one is
    typedef struct packed {
        logic [KEY_SLOTS-1:0]      hit;
        logic [KEY_SLOTS-1:0][1:0] kind;
        logic [KEY_SLOTS-1:0][6:0] code;
        logic                      caps;
    } entry_t;

    // non-letter keys from 0x1E up; zero means unmapped
    function automatic logic [6:0] sym_char(input logic [4:0] idx, input logic shifted);
        logic [6:0] plain;
        logic [6:0] shft;
        begin
            case (idx)
                5'd0:  begin plain = 7'h31; shft = 7'h21; end
                5'd1:  begin plain = 7'h32; shft = 7'h40; end
                5'd2:  begin plain = 7'h33; shft = 7'h23; end
                5'd3:  begin plain = 7'h34; shft = 7'h24; end
                5'd4:  begin plain = 7'h35; shft = 7'h25; end
                5'd5:  begin plain = 7'h36; shft = 7'h5E; end
                5'd6:  begin plain = 7'h37; shft = 7'h26; end
                5'd7:  begin plain = 7'h38; shft = 7'h2A; end
                5'd8:  begin plain = 7'h39; shft = 7'h28; end
                5'd9:  begin plain = 7'h30; shft = 7'h29; end
                5'd10: begin plain = 7'h0A; shft = 7'h0A; end
                5'd11: begin plain = 7'h1B; shft = 7'h1B; end
                5'd12: begin plain = 7'h08; shft = 7'h08; end
                5'd13: begin plain = 7'h09; shft = 7'h09; end
                5'd14: begin plain = 7'h20; shft = 7'h20; end
                5'd15: begin plain = 7'h2D; shft = 7'h5F; end
                5'd16: begin plain = 7'h3D; shft = 7'h2B; end
                5'd17: begin plain = 7'h5B; shft = 7'h7B; end
                5'd18: begin plain = 7'h5D; shft = 7'h7D; end
                5'd19: begin plain = 7'h5C; shft = 7'h7C; end
                5'd20: begin plain = 7'h00; shft = 7'h00; end
                5'd21: begin plain = 7'h3B; shft = 7'h3A; end
                5'd22: begin plain = 7'h27; shft = 7'h22; end
                5'd23: begin plain = 7'h60; shft = 7'h7E; end
                5'd24: begin plain = 7'h2C; shft = 7'h3C; end
                5'd25: begin plain = 7'h2E; shft = 7'h3E; end
                5'd26: begin plain = 7'h2F; shft = 7'h3F; end
                default: begin plain = 7'h00; shft = 7'h00; end
            endcase
            sym_char = shifted ? shft : plain;
        end
    endfunction

endpackage

>>> sv/hbk_front.sv
// Front end: takes a report, tracks previous keys, caps lock and the config bit,
// and classifies every slot into an entry. Uses hbk_pkg.
module hbk_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data,
    input  logic           accept,
    input  logic [7:0]     modifier_bits,
    input  hbk_pkg::keys_t keys,
    output hbk_pkg::entry_t entry
);

    hbk_pkg::keys_t prev_keys_reg;
    logic           caps_reg;
    logic           caps_next;
    logic           target_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic caps_held;
        logic toggle;
        logic shift;
        logic ctrl;
        logic in_prev;
        logic case_shift;
        logic [7:0] kc;
        logic [6:0] ch;
        logic [7:0] sym_off;

        caps_held = 1'b0;
        toggle    = 1'b0;
        shift     = |(modifier_bits & hbk_pkg::MOD_SHIFT);
        ctrl      = |(modifier_bits & hbk_pkg::MOD_CTRL);
        for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++)
        begin
            caps_held = caps_held | (prev_keys_reg[j] == hbk_pkg::CAPS_CODE);
            toggle    = toggle ^ (keys[j] == hbk_pkg::CAPS_CODE);
        end
        caps_next  = caps_reg ^ (toggle & ~caps_held);
        entry.caps = caps_next;

        for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++)
        begin
            kc      = keys[i];
            in_prev = 1'b0;
            for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++)
                in_prev = in_prev | (prev_keys_reg[j] == kc);

            case_shift = shift;
            ch         = 7'h00;
            sym_off    = kc - hbk_pkg::SYM_FIRST;
            if (kc >= hbk_pkg::LETTER_FIRST && kc <= hbk_pkg::LETTER_LAST)
            begin
                case_shift = shift ^ caps_next;
                ch = (case_shift ? 7'h41 : 7'h61) + (kc[6:0] - hbk_pkg::LETTER_FIRST[6:0]);
            end
            else if (kc >= hbk_pkg::SYM_FIRST && kc <= hbk_pkg::SYM_LAST)
            begin
                ch = hbk_pkg::sym_char(sym_off[4:0], case_shift);
            end

            entry.kind[i] = hbk_pkg::EV_CHAR;
            entry.code[i] = ch;
            entry.hit[i]  = 1'b0;
            if (kc != 8'h00 && !kc[7] && !in_prev)
            begin
                if (ctrl && target_reg && kc == hbk_pkg::KEY_C_CODE)
                begin
                    entry.kind[i] = hbk_pkg::EV_INTR;
                    entry.code[i] = 7'h00;
                    entry.hit[i]  = 1'b1;
                end
                else if (ctrl && target_reg && kc == hbk_pkg::KEY_BSLASH_CODE)
                begin
                    entry.kind[i] = hbk_pkg::EV_QUIT;
                    entry.code[i] = 7'h00;
                    entry.hit[i]  = 1'b1;
                end
                else
                begin
                    entry.hit[i] = (ch != 7'h00);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
            caps_reg      <= 1'b0;
            target_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                target_reg <= cfg_data;
            if (accept)
            begin
                prev_keys_reg <= keys;
                caps_reg      <= caps_next;
            end
        end
    end

endmodule

>>> sv/hbk_queue.sv
// Short queue of classified reports between front and back ends.
// Uses hbk_pkg for the entry type and depth.
module hbk_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  hbk_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output hbk_pkg::entry_t rd_data,
    output logic            empty
);

    hbk_pkg::entry_t                mem [hbk_pkg::QDEPTH];
    logic [hbk_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [hbk_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [hbk_pkg::QCNT_W-1:0]     count_reg;

    assign full    = (count_reg == hbk_pkg::QCNT_W'(hbk_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    function automatic logic [hbk_pkg::QPTR_W-1:0] bump(input logic [hbk_pkg::QPTR_W-1:0] p);
        begin
            if (p == hbk_pkg::QPTR_W'(hbk_pkg::QDEPTH - 1))
                bump = '0;
            else
                bump = p + 1'b1;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/hbk_back.sv
// Back end: walks the slot mask of one entry and emits one event per cycle
// into an output register while it is free or being popped. Uses hbk_pkg.
module hbk_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hbk_pkg::entry_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [1:0]      event_kind,
    output logic [6:0]      char_code,
    output logic            caps_lock_on,
    output logic            last_in_run
);

    hbk_pkg::entry_t               ent_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic [hbk_pkg::KEY_SLOTS-1:0] mask_reg;
    logic [hbk_pkg::KEY_SLOTS-1:0] mask_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    kind_reg;
    logic [6:0]                    code_reg;
    logic                          caps_reg;
    logic                          last_reg;

    logic [hbk_pkg::SLOT_W-1:0]    sel;
    logic [hbk_pkg::KEY_SLOTS-1:0] rest;
    logic                          out_free;
    logic                          emit;

    // lowest pending slot first, matching slot order
    always_comb
    begin
        logic found;
        found = 1'b0;
        sel   = '0;
        rest  = mask_reg;
        for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                found   = 1'b1;
                sel     = hbk_pkg::SLOT_W'(i);
                rest[i] = 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || pop;
    assign emit     = busy_reg && out_free;
    assign q_pop    = !busy_reg && !q_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            mask_next      = rest;
            busy_next      = |rest;
        end
        if (q_pop)
        begin
            mask_next = q_data.hit;
            busy_next = |q_data.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            ent_reg <= q_data;
        if (emit)
        begin
            kind_reg <= ent_reg.kind[sel];
            code_reg <= ent_reg.code[sel];
            caps_reg <= ent_reg.caps;
            last_reg <= ~(|rest);
        end
    end

    assign empty        = !out_valid_reg;
    assign event_kind   = kind_reg;
    assign char_code    = code_reg;
    assign caps_lock_on = caps_reg;
    assign last_in_run  = last_reg;

endmodule

>>> sv/hid_boot_keyboard_decoder.sv
// HID boot keyboard report decoder. A report is taken whenever full
// is low; the front end classifies all six slots at once and queues the report
// (two reports deep). The back end then loads one report at a time and gives
// its events one by one, taking no new report until the current one is done;
// this walk, one event per cycle while output is free, sets the sustained rate.
// Events leave through a single output register read with empty/pop.
// Depends on hbk_pkg, hbk_front, hbk_queue, hbk_back.
module hid_boot_keyboard_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] event_kind,
    output logic [6:0] char_code,
    output logic       caps_lock_on,
    output logic       last_in_run
);

    hbk_pkg::keys_t  keys;
    hbk_pkg::entry_t front_entry;
    hbk_pkg::entry_t q_data;
    logic            accept;
    logic            q_empty;
    logic            q_pop;

    assign keys   = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};
    assign accept = push && !full;

    hbk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .modifier_bits (modifier_bits),
        .keys          (keys),
        .entry         (front_entry)
    );

    hbk_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    hbk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .char_code    (char_code),
        .caps_lock_on (caps_lock_on),
        .last_in_run  (last_in_run)
    );

endmodule
